FILE: src/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
package sem_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 11;
  localparam int unsigned SumW = 21;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_CALC,
    ST_SQRT,
    ST_EMIT
  } sem_state_t;

  // window column selection and bottom clamp for one result
  typedef struct packed {
    logic shifted;
    logic bottom;
  } sem_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     mem_rd;
    logic     shift;
    logic     calc;
    logic     sqrt_start;
    logic     sqrt_step;
    sem_sel_t sel;
  } sem_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sqrt_done;
  } sem_stat_t;

endpackage

FILE: src/sem_if.sv
// valid/ready stream interfaces for pixels, results and configuration
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_res;
  logic [9:0] out_col;
  logic [9:0] out_row;
  logic       last_of_run;
  logic       frame_done;
  modport source (output valid, output edge_res, output out_col, output out_row,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input edge_res, input out_col, input out_row,
                input last_of_run, input frame_done, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/sem_datapath.sv
// line stores, 3x3 window, sobel gradients and bit-serial square root
module sem_datapath #(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned IdxW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sem_pkg::sem_cmd_t    cmd,
  output sem_pkg::sem_stat_t   stat,
  input  logic [IdxW-1:0]      idx,
  input  logic                 row_is_one,
  input  logic                 col_is_zero,
  input  logic [7:0]           pixel,
  output logic [7:0]           mag
);
  import sem_pkg::*;

  logic [PixW-1:0] upper_mem [MaxWidth];
  logic [PixW-1:0] middle_mem [MaxWidth];
  logic [PixW-1:0] top_rd_r, mid_rd_r;
  logic [PixW-1:0] win_r [3][3];
  logic [PixW-1:0] new_col [3];
  logic [PixW-1:0] p [3][3];
  logic signed [11:0] gx, gy;
  logic signed [11:0] gx_r, gy_r;
  logic signed [23:0] gx_sq, gy_sq;
  logic [SumW-1:0] sq_r;
  logic [7:0] root_r;
  logic [7:0] bit_r;
  logic [7:0] trial;
  logic [15:0] trial_sq;

  // line store read, then write back the shifted column
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      top_rd_r <= upper_mem[idx];
      mid_rd_r <= middle_mem[idx];
    end
    if (cmd.shift) begin
      upper_mem[idx] <= mid_rd_r;
      middle_mem[idx] <= pixel;
    end
  end

  // incoming column, top row replicated on the second image row
  always_comb begin
    new_col[0] = row_is_one ? mid_rd_r : top_rd_r;
    new_col[1] = mid_rd_r;
    new_col[2] = pixel;
  end

  // window shift with left border replication
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int j = 0; j < 3; j++) begin
        win_r[0][j] <= col_is_zero ? new_col[j] : win_r[1][j];
        win_r[1][j] <= col_is_zero ? new_col[j] : win_r[2][j];
        win_r[2][j] <= new_col[j];
      end
    end
  end

  // neighborhood p[row][col] from selected columns
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [1:0] c;
      c = cmd.sel.shifted ? ((i == 2) ? 2'd2 : 2'(i + 1)) : 2'(i);
      if (cmd.sel.bottom) begin
        p[0][i] = win_r[c][1];
        p[1][i] = win_r[c][2];
        p[2][i] = win_r[c][2];
      end else begin
        p[0][i] = win_r[c][0];
        p[1][i] = win_r[c][1];
        p[2][i] = win_r[c][2];
      end
    end
    gx = ($signed({4'd0, p[0][2]}) + $signed({3'd0, p[1][2], 1'b0}) + $signed({4'd0, p[2][2]}))
       - ($signed({4'd0, p[0][0]}) + $signed({3'd0, p[1][0], 1'b0}) + $signed({4'd0, p[2][0]}));
    gy = ($signed({4'd0, p[2][0]}) + $signed({3'd0, p[2][1], 1'b0}) + $signed({4'd0, p[2][2]}))
       - ($signed({4'd0, p[0][0]}) + $signed({3'd0, p[0][1], 1'b0}) + $signed({4'd0, p[0][2]}));
  end

  // full-width squares of the gradients
  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;

  // gradient registers, then sum of squares
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (cmd.sqrt_start) begin
      sq_r <= gx_sq[SumW-1:0] + gy_sq[SumW-1:0];
    end
  end

  // one root bit per cycle, msb first
  assign trial = root_r | bit_r;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_start) begin
      bit_r <= 8'h80;
      root_r <= '0;
    end else if (cmd.sqrt_step && bit_r != '0) begin
      if (sq_r[SumW-1:16] != '0) begin
        root_r <= 8'hff;
      end else if (trial_sq <= sq_r[15:0]) begin
        root_r <= trial;
      end
      bit_r <= bit_r >> 1;
    end
  end

  assign stat.sqrt_done = (bit_r == '0);
  assign mag = root_r;

`ifndef SYNTH
  a_root_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sqrt_step && bit_r == 8'h01 && sq_r[SumW-1:16] != '0) |=> (root_r == 8'hff))
    else $error("saturated root not 255");
  a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.calc) |-> (gx_r <= 12'sd1020 && gx_r >= -12'sd1020 &&
                         gy_r <= 12'sd1020 && gy_r >= -12'sd1020))
    else $error("gradient out of range");
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |=> !stat.sqrt_done)
    else $error("root done right after start");
`endif

endmodule

FILE: src/sem_ctrl.sv
// controller: counters, result sequencing and handshakes
module sem_ctrl #(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned MaxHeight = 1024,
  parameter int unsigned IdxW = 10,
  parameter int unsigned CntW = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [10:0]         line_width,
  input  logic [10:0]         frame_height,
  output sem_pkg::sem_cmd_t   cmd,
  input  sem_pkg::sem_stat_t  stat,
  output logic [IdxW-1:0]     idx,
  output logic                row_is_one,
  output logic                col_is_zero,
  input  logic [7:0]          mag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          edge_res,
  output logic [9:0]          out_col,
  output logic [9:0]          out_row,
  output logic                last_of_run,
  output logic                frame_done
);
  import sem_pkg::*;

  sem_state_t state_r, state_nxt;
  logic [CntW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CntW:0] w_use, h_use;
  logic last_col_r, last_row_r;
  logic [1:0] k_r, k_nxt;
  logic [3:0] emit_mask;
  logic out_valid_r;
  logic [7:0] res_r;
  logic [9:0] rcol_r, rrow_r;
  logic rlast_r, rdone_r;
  logic has_more;
  logic [1:0] next_k;
  logic pos_ok;
  logic sqrt_run_r;
  logic [CntW-1:0] pcol_r, prow_r;

  // sizes in use, clamped to the supported range
  always_comb begin
    w_use = (CntW+1)'(line_width);
    if (line_width < 11'd2) w_use = (CntW+1)'(2);
    else if ((CntW+1)'(line_width) > (CntW+1)'(MaxWidth)) w_use = (CntW+1)'(MaxWidth);
    h_use = (CntW+1)'(frame_height);
    if (frame_height < 11'd2) h_use = (CntW+1)'(2);
    else if ((CntW+1)'(frame_height) > (CntW+1)'(MaxHeight)) h_use = (CntW+1)'(MaxHeight);
  end

  assign idx = (col_r >= CntW'(MaxWidth)) ? IdxW'(MaxWidth - 1) : col_r[IdxW-1:0];
  assign row_is_one = (row_r == CntW'(1));
  assign col_is_zero = (col_r == '0);
  assign in_ready = (state_r == ST_IDLE);

  // which of up to four results this pixel makes
  always_comb begin
    // counters move on at the shift, so later states use the saved position
    pos_ok = (state_r == ST_SHIFT) ? (row_r != '0 && col_r != '0)
                                   : (prow_r != '0 && pcol_r != '0);
    emit_mask = '0;
    if (pos_ok) begin
      emit_mask[0] = 1'b1;
      emit_mask[1] = last_col_r;
      emit_mask[2] = last_row_r;
      emit_mask[3] = last_row_r && last_col_r;
    end
    has_more = 1'b0;
    next_k = k_r;
    for (int i = 3; i >= 0; i--) begin
      if (emit_mask[i] && 2'(i) > k_r) begin
        has_more = 1'b1;
        next_k = 2'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = (emit_mask != '0) ? ST_CALC : ST_IDLE;
      ST_CALC: state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_run_r && stat.sqrt_done && !out_valid_r) state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = has_more ? ST_CALC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.sel.shifted = k_r[0];
    cmd.sel.bottom = k_r[1];
    case (state_r)
      ST_IDLE: cmd.mem_rd = in_valid;
      ST_SHIFT: cmd.shift = 1'b1;
      ST_CALC: cmd.calc = 1'b1;
      ST_SQRT: begin
        cmd.sqrt_start = !sqrt_run_r;
        cmd.sqrt_step = sqrt_run_r;
      end
      default: cmd.mem_rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sqrt_run_r <= 1'b0;
    else if (state_r == ST_SQRT) sqrt_run_r <= 1'b1;
    else sqrt_run_r <= 1'b0;
  end

  // counter update when the pixel enters the window
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (state_r == ST_SHIFT) begin
      if (last_col_r) begin
        col_nxt = '0;
        row_nxt = last_row_r ? '0 : row_r + CntW'(1);
      end else begin
        col_nxt = col_r + CntW'(1);
      end
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (state_r == ST_SHIFT) k_nxt = '0;
    else if (state_r == ST_EMIT) k_nxt = next_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r <= '0;
      row_r <= '0;
      k_r <= '0;
      last_col_r <= 1'b0;
      last_row_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      if (state_r == ST_READ) begin
        last_col_r <= {1'b0, col_r} >= w_use - (CntW+1)'(1);
        last_row_r <= {1'b0, row_r} >= h_use - (CntW+1)'(1);
      end
      if (state_r == ST_SHIFT) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // position of the pixel just entered, kept for the later states
  always_ff @(posedge clk) begin
    if (state_r == ST_SHIFT) begin
      pcol_r <= col_r;
      prow_r <= row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      res_r <= mag;
      rcol_r <= k_r[0] ? pcol_r[9:0] : 10'(pcol_r - CntW'(1));
      rrow_r <= k_r[1] ? prow_r[9:0] : 10'(prow_r - CntW'(1));
      rlast_r <= !has_more;
      rdone_r <= !has_more && last_row_r && last_col_r;
    end
  end

  assign out_valid = out_valid_r;
  assign edge_res = res_r;
  assign out_col = rcol_r;
  assign out_row = rrow_r;
  assign last_of_run = rlast_r;
  assign frame_done = rdone_r;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.calc && !cmd.shift)
    else $error("pixel taken while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !out_valid_r)
    else $error("result overwritten");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_done) |-> last_of_run)
    else $error("frame end not last of run");
`endif

endmodule

FILE: src/sobel_edge_magnitude.sv
// Sobel 3x3 edge magnitude, top level
// Usage: pixels enter on the in_ channel in raster order, one request per pixel.
// Configuration writes on cfg_ set line_width (index 0) and frame_height
// (index 1); write only while idle. Results leave on out_ with their column
// and row; each pixel gives 0 to 4 results, one row and one column behind.
// Steps: a pixel is handled by reading the line stores, shifting the window
// and deciding its results; each result then takes a gradient register load,
// the sum of squares, an 8-step bit-serial square root, a check that it has
// finished, then the output register load. The square root unit, shared by
// all results, sets the rate.
// Reset: counters and window clear, sizes return to 640 by 480; line
// stores are not cleared; the first image row reads them before writing but gives no results.
// Stall: a waiting result holds in the output register; the next result is
// computed meanwhile and waits to load, and no pixel is taken until all
// results of the current pixel are loaded.
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input logic clk,
  input logic rst_n,
  sem_pix_if.sink   in_ch,
  sem_res_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);
  import sem_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_WIDTH);
  localparam int unsigned CntW = 13;

  logic [CfgW-1:0] width_r, height_r;
  sem_cmd_t cmd;
  sem_stat_t stat;
  logic [IdxW-1:0] idx;
  logic row_is_one, col_is_zero;
  logic [7:0] mag;
  logic [7:0] in_pix_r;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd640;
      height_r <= 11'd480;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_LINE_WIDTH: width_r <= cfg_ch.data;
        REG_FRAME_HEIGHT: height_r <= cfg_ch.data;
        default: width_r <= width_r;
      endcase
    end
  end

  sem_ctrl #(
    .MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT), .IdxW(IdxW), .CntW(CntW)
  ) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .line_width(width_r), .frame_height(height_r),
    .cmd, .stat, .idx, .row_is_one, .col_is_zero, .mag,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .edge_res(out_ch.edge_res), .out_col(out_ch.out_col), .out_row(out_ch.out_row),
    .last_of_run(out_ch.last_of_run), .frame_done(out_ch.frame_done)
  );

  sem_datapath #(.MaxWidth(MAX_WIDTH), .IdxW(IdxW)) u_dp (
    .clk, .rst_n, .cmd, .stat, .idx, .row_is_one, .col_is_zero,
    .pixel(in_pix_r), .mag
  );

  // pixel captured at acceptance
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_pix_r <= in_ch.pixel;
  end

`ifndef SYNTH
  a_cfg_width: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.index == REG_LINE_WIDTH) |=> (width_r == $past(cfg_ch.data)))
    else $error("width write lost");
  a_cfg_height: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.index == REG_FRAME_HEIGHT) |=> (height_r == $past(cfg_ch.data)))
    else $error("height write lost");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped under stall");
`endif

endmodule
